// ----- src/rbf_pkg.sv -----
package rbf_pkg;

    // One channel of a pixel and the packed pixel word (blue in the low byte).
    localparam int CH_W   = 8;
    localparam int CH_N   = 3;
    localparam int PIX_W  = CH_N * CH_W;
    localparam int CH_MAX = 255;

    // Line width register.
    localparam int          LW_W           = 12;
    localparam logic [11:0] LINE_WIDTH_RST = 12'd640;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ----- src/rgb_box_filter_5x5_core.sv -----
// Streaming KERNEL_SIZE x KERNEL_SIZE box filter over 8-bit BGR pixels in raster
// order. Every accepted word on the s_ side produces exactly one word on the m_
// side, in order: the per-channel floor of the mean over the window whose lower
// right corner is the incoming pixel, so the window center lies two rows and two
// columns back for the default 5x5 size. While that window still reaches outside
// the frame (the first KERNEL_SIZE-1 rows and columns), m_window_ok is 0 and the
// channels read 0. The block takes one word every clock cycle when m_ready stays
// high; each word passes stage 1, the window sums and the output register. That
// rate is set by the line store, a single memory of MAX_WIDTH words, each holding
// one pixel of every stored line, which is read once and written once per pixel.
// s_frame_start restarts row and column counting on the word that carries it.
// line_width may only be written while the pipeline is empty; values of 0 act as
// 1 and values above MAX_WIDTH act as MAX_WIDTH.
module rgb_box_filter_5x5_core import rbf_pkg::*; #(
    parameter int MAX_WIDTH   = 2048,
    parameter int KERNEL_SIZE = 5
) (
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            cfg_wr_en,
    input  logic [LW_W-1:0] cfg_wr_data,

    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_frame_start,
    input  logic [CH_W-1:0] s_in_blue,
    input  logic [CH_W-1:0] s_in_green,
    input  logic [CH_W-1:0] s_in_red,

    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_window_ok,
    output logic [CH_W-1:0] m_out_blue,
    output logic [CH_W-1:0] m_out_green,
    output logic [CH_W-1:0] m_out_red
);

    localparam int KK       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int NLINES   = KERNEL_SIZE - 1;
    localparam int LS_W     = NLINES * PIX_W;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W    = (CNT_W > LW_W) ? CNT_W : LW_W;
    localparam int ROW_W    = $clog2(KERNEL_SIZE);
    localparam int SUM_MAX  = KK * CH_MAX;
    localparam int SUM_W    = $clog2(SUM_MAX + 1);
    // Division by KK is a multiply by a rounded-up reciprocal. With the shift
    // chosen so that 2**RECIP_SH exceeds SUM_MAX*KK, the rounding error never
    // reaches the next integer, so the quotient is exact over the whole range.
    localparam int RECIP_SH = $clog2(SUM_MAX * KK + 1);
    localparam int RECIP_M  = (2**RECIP_SH + KK - 1) / KK;
    localparam int RM_W     = $clog2(RECIP_M + 1);
    localparam int PROD_W   = SUM_W + RM_W;

    // Configuration register.
    logic [LW_W-1:0]  line_width_reg;

    // Position counters. The row count only needs to reach KERNEL_SIZE-1,
    // after which every later row sees a full window height.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // Stage 1: the accepted pixel waits for its column of the line store.
    logic             s1_valid_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_ok_reg;
    logic             s1_fwd_reg;
    logic [LS_W-1:0]  s1_fwd_data_reg;

    // Stage 2: the window sums hold this word's totals.
    logic             s2_valid_reg;
    logic             s2_ok_reg;

    // Output register.
    logic             m_valid_reg;
    logic             m_ok_reg;
    logic [CH_W-1:0]  m_out_reg [CH_N];

    logic             m_open;
    logic             s2_open;
    logic             s1_open;
    logic             s_accept;
    logic             s1_adv;

    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] col_inc;
    logic [COL_W-1:0] col_base;
    logic [COL_W-1:0] col_in;
    logic [ROW_W-1:0] row_in;
    logic             ok_in;
    logic             wrap;

    logic [LS_W-1:0]  ls_rd_data;
    logic [LS_W-1:0]  ls_lines;
    logic [LS_W-1:0]  ls_wr_data;
    logic             fwd_hit;

    logic [KERNEL_SIZE*PIX_W-1:0] col_pix;
    logic [SUM_W-1:0]             win_sum [CH_N];
    logic [PROD_W-1:0]            prod    [CH_N];

    // ------------------------------------------------------------------
    // Handshake. Each stage may load when it is empty or when the stage
    // after it is moving, so a stalled output still lets the earlier stages
    // fill up behind it.
    // ------------------------------------------------------------------
    assign m_open   = !m_valid_reg || m_ready;
    assign s2_open  = !s2_valid_reg || m_open;
    assign s1_open  = !s1_valid_reg || s2_open;
    assign s_ready  = s1_open;
    assign s_accept = s_valid && s1_open;
    assign s1_adv   = s1_valid_reg && s2_open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
        end else if (cfg_wr_en) begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Position of the incoming pixel and the next position.
    // ------------------------------------------------------------------
    always_comb begin
        if (line_width_reg == '0) begin
            eff_w = CMP_W'(1);
        end else if (CMP_W'(line_width_reg) > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = CMP_W'(line_width_reg);
        end

        col_base = s_frame_start ? '0 : col_reg;
        row_in   = s_frame_start ? '0 : row_reg;
        // A column left over from a wider line restarts at zero.
        col_in   = (CMP_W'(col_base) >= eff_w) ? '0 : col_base;

        ok_in = (row_in == ROW_W'(KERNEL_SIZE - 1)) &&
                (CMP_W'(col_in) >= CMP_W'(KERNEL_SIZE - 1));

        col_inc  = CMP_W'(col_in) + CMP_W'(1);
        wrap     = (col_inc >= eff_w);
        col_next = wrap ? '0 : col_inc[COL_W-1:0];
        if (wrap && (row_in != ROW_W'(KERNEL_SIZE - 1))) begin
            row_next = row_in + ROW_W'(1);
        end else begin
            row_next = row_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store. Each word holds one column position of the NLINES stored
    // lines, the newest line in the low pixel. It is read when a pixel is
    // accepted and written back, shifted by one line, when that pixel leaves
    // stage 1. With a line one pixel wide the next pixel reads the same word
    // in the cycle it is written, so that word is forwarded around the memory.
    // ------------------------------------------------------------------
    assign ls_lines   = s1_fwd_reg ? s1_fwd_data_reg : ls_rd_data;
    assign ls_wr_data = {ls_lines[LS_W-PIX_W-1:0], s1_pix_reg};
    assign fwd_hit    = s1_adv && (s1_col_reg == col_in);

    rbf_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr_data),
        .rd_en   (s_accept),
        .rd_addr (col_in),
        .rd_data (ls_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_open) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg      <= {s_in_red, s_in_green, s_in_blue};
            s1_col_reg      <= col_in;
            s1_ok_reg       <= ok_in;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= ls_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Window: the new column is the stored lines plus the incoming pixel.
    // Only the channel totals matter, so the order within the column is free.
    // ------------------------------------------------------------------
    assign col_pix = {ls_lines, s1_pix_reg};

    rbf_window_sum #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_window_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_adv),
        .col_pix  (col_pix),
        .win_sum  (win_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_open) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_ok_reg <= s1_ok_reg;
        end
    end

    // ------------------------------------------------------------------
    // Mean: window total times the reciprocal of KK, then the output register.
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            prod[c] = PROD_W'(win_sum[c]) * PROD_W'(RECIP_M);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_open) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && m_open) begin
            m_ok_reg <= s2_ok_reg;
            for (int c = 0; c < CH_N; c++) begin
                m_out_reg[c] <= s2_ok_reg ? prod[c][RECIP_SH +: CH_W] : '0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_window_ok = m_ok_reg;
    assign m_out_blue  = m_out_reg[0];
    assign m_out_green = m_out_reg[1];
    assign m_out_red   = m_out_reg[2];

endmodule

// ----- src/rbf_ram.sv -----
module rbf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rbf_window_sum.sv -----
module rbf_window_sum import rbf_pkg::*; #(
    parameter int KERNEL_SIZE = 5
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         shift_en,
    input  logic [KERNEL_SIZE*PIX_W-1:0]                 col_pix,
    output logic [$clog2(KERNEL_SIZE*KERNEL_SIZE*CH_MAX+1)-1:0] win_sum [CH_N]
);

    localparam int CS_W  = $clog2(KERNEL_SIZE * CH_MAX + 1);
    localparam int SUM_W = $clog2(KERNEL_SIZE * KERNEL_SIZE * CH_MAX + 1);

    // The window is kept as one column sum per channel for the newest
    // KERNEL_SIZE-1 columns. Each shift rebuilds the total from those sums and
    // the incoming column, so the total depends only on the columns in the window.
    logic [CS_W-1:0]  colsum_reg [CH_N][KERNEL_SIZE-1];
    logic [SUM_W-1:0] sum_reg    [CH_N];
    logic [CS_W-1:0]  new_cs     [CH_N];
    logic [SUM_W-1:0] prev_sum   [CH_N];
    logic [SUM_W-1:0] sum_next   [CH_N];

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            new_cs[c]   = '0;
            prev_sum[c] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                new_cs[c] = new_cs[c] + CS_W'(col_pix[k*PIX_W + c*CH_W +: CH_W]);
            end
            for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
                prev_sum[c] = prev_sum[c] + SUM_W'(colsum_reg[c][k]);
            end
            sum_next[c] = prev_sum[c] + SUM_W'(new_cs[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CH_N; c++) begin
                sum_reg[c] <= '0;
                for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
                    colsum_reg[c][k] <= '0;
                end
            end
        end else if (shift_en) begin
            for (int c = 0; c < CH_N; c++) begin
                for (int k = 0; k < KERNEL_SIZE - 2; k++) begin
                    colsum_reg[c][k] <= colsum_reg[c][k+1];
                end
                colsum_reg[c][KERNEL_SIZE-2] <= new_cs[c];
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            win_sum[c] = sum_reg[c];
        end
    end

endmodule

// ----- src/rbf_checker.sv -----
module rbf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_window_ok,
    input logic [7:0] m_out_blue,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_red
);

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word present after reset");

    // The input side only blocks when every stage is full behind a stalled output.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input blocked while output side is free");

    // Border words carry zero channels.
    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_window_ok) |->
            (m_out_blue == 8'd0 && m_out_green == 8'd0 && m_out_red == 8'd0))
        else $error("nonzero channel on a border word");

    // A stalled output word holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_window_ok) && $stable(m_out_blue) &&
             $stable(m_out_green) && $stable(m_out_red)))
        else $error("output word changed while stalled");

endmodule

bind rgb_box_filter_5x5_core rbf_checker u_rbf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_window_ok (m_window_ok),
    .m_out_blue  (m_out_blue),
    .m_out_green (m_out_green),
    .m_out_red   (m_out_red)
);
